/* rtl/pfvs_pkg.sv */
// Shared types and constants for the page frame victim selector.
package pfvs_pkg;

  localparam int KIND_W   = 2;
  localparam int FRAME_W  = 4;
  localparam int MASK_W   = 16;
  localparam int AGE_W    = 8;
  localparam int POLICY_W = 2;
  localparam int VICTIM_W = 4;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [POLICY_W-1:0] policy_t;
  typedef logic [AGE_W-1:0]    age_t;

  localparam kind_t KIND_SELECT = 2'd0;
  localparam kind_t KIND_AGE    = 2'd1;
  localparam kind_t KIND_FLAGS  = 2'd2;

  localparam policy_t POL_RANDOM = 2'd0;
  localparam policy_t POL_LRU    = 2'd1;
  localparam policy_t POL_FIFO   = 2'd2;

endpackage

/* rtl/pfvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/page_frame_victim_select_top.sv */
// Page frame victim selector: frame flags, aging counters and victim scan.
//
// A select or ageing-tick beat scans every frame in ST_SCAN: one frame is
// examined per cycle through the aging-counter RAM's single read port,
// then ST_DRAIN covers the registered RAM read and ST_DONE forms the
// result. busy is high through those states. A set-flags beat completes at the
// edge it is taken and leaves busy low. A select beat yields one result,
// shown on the out_ ports for exactly one cycle with out_valid high; it must
// be taken then, as there is no back-pressure. Aging counters read as zero
// until first written, so no clearing pass follows reset.
module page_frame_victim_select_top #(
  parameter int FRAME_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pfvs_pkg::KIND_W-1:0]    in_kind,
  input  logic [pfvs_pkg::FRAME_W-1:0]   in_frame,
  input  logic                           in_mapped,
  input  logic                           in_protected_bit,
  input  logic [pfvs_pkg::MASK_W-1:0]    in_ref_mask,
  input  logic [pfvs_pkg::MASK_W-1:0]    in_random_bits,
  input  logic                           cfg_we,
  input  logic [pfvs_pkg::POLICY_W-1:0]  cfg_wdata,
  output logic                           out_valid,
  output logic [pfvs_pkg::VICTIM_W-1:0]  out_victim,
  output logic                           out_victim_was_mapped,
  output logic                           out_out_of_memory
);

  import pfvs_pkg::*;

  localparam int IDXW = (FRAME_COUNT > 2) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAME_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;
  logic proc_v_r, proc_v_nxt;
  logic [IDXW-1:0] proc_idx_r, proc_idx_nxt;

  kind_t   kind_r, kind_nxt;
  policy_t policy_r, policy_nxt;
  logic [MASK_W-1:0] ref_r, ref_nxt;
  logic [MASK_W-1:0] coin_r, coin_nxt;

  logic [FRAME_COUNT-1:0] map_r, map_nxt;
  logic [FRAME_COUNT-1:0] prot_r, prot_nxt;
  logic [FRAME_COUNT-1:0] age_vld_r, age_vld_nxt;
  logic [IDXW-1:0] fifo_ptr_r, fifo_ptr_nxt;

  // scan trackers
  logic free_hit_r, free_hit_nxt;
  logic [IDXW-1:0] free_idx_r, free_idx_nxt;
  logic seen_r, seen_nxt;
  logic [IDXW-1:0] last_idx_r, last_idx_nxt;
  logic rnd_hit_r, rnd_hit_nxt;
  logic [IDXW-1:0] rnd_idx_r, rnd_idx_nxt;
  logic [IDXW-1:0] lru_idx_r, lru_idx_nxt;
  age_t lru_val_r, lru_val_nxt;
  logic hi_hit_r, hi_hit_nxt;
  logic [IDXW-1:0] hi_idx_r, hi_idx_nxt;
  logic [IDXW-1:0] lo_idx_r, lo_idx_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [VICTIM_W-1:0] out_victim_r, out_victim_nxt;
  logic out_mapped_r, out_mapped_nxt;
  logic out_oom_r, out_oom_nxt;

  logic [IDXW-1:0] ram_raddr;
  age_t ram_rdata;
  logic ram_we;
  age_t ram_wdata;

  logic accept;
  logic p_prot, p_map, p_ref, p_coin;
  logic [8:0] p_idx9;
  age_t p_age;
  logic found;
  logic [IDXW-1:0] pick;
  logic [8:0] pick9;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  pfvs_ram #(
    .WIDTH(AGE_W),
    .DEPTH(FRAME_COUNT)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (proc_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cnt_r;

  always_comb begin
    p_idx9 = 9'(proc_idx_r);
    p_prot = prot_r[proc_idx_r];
    p_map  = map_r[proc_idx_r];
    p_ref  = (p_idx9 < 9'd16) ? ref_r[p_idx9[3:0]] : 1'b0;
    p_coin = (p_idx9 < 9'd16) ? coin_r[p_idx9[3:0]] : 1'b0;
    p_age  = age_vld_r[proc_idx_r] ? ram_rdata : '0;
  end

  assign ram_we    = proc_v_r && (kind_r == KIND_AGE) && p_map;
  assign ram_wdata = {p_ref, p_age[AGE_W-1:1]};

  // result selection from the trackers once the scan has finished
  always_comb begin
    found = 1'b0;
    pick  = '0;
    if (free_hit_r) begin
      found = 1'b1;
      pick  = free_idx_r;
    end else begin
      unique case (policy_r)
        POL_RANDOM: begin
          found = seen_r;
          pick  = rnd_hit_r ? rnd_idx_r : last_idx_r;
        end
        POL_LRU: begin
          found = seen_r;
          pick  = lru_idx_r;
        end
        POL_FIFO: begin
          found = seen_r;
          pick  = hi_hit_r ? hi_idx_r : lo_idx_r;
        end
        default: begin
          found = 1'b0;
          pick  = '0;
        end
      endcase
    end
    pick9 = 9'(pick);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    proc_v_nxt    = 1'b0;
    proc_idx_nxt  = cnt_r;
    kind_nxt      = kind_r;
    policy_nxt    = policy_r;
    ref_nxt       = ref_r;
    coin_nxt      = coin_r;
    map_nxt       = map_r;
    prot_nxt      = prot_r;
    age_vld_nxt   = age_vld_r;
    fifo_ptr_nxt  = fifo_ptr_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    seen_nxt      = seen_r;
    last_idx_nxt  = last_idx_r;
    rnd_hit_nxt   = rnd_hit_r;
    rnd_idx_nxt   = rnd_idx_r;
    lru_idx_nxt   = lru_idx_r;
    lru_val_nxt   = lru_val_r;
    hi_hit_nxt    = hi_hit_r;
    hi_idx_nxt    = hi_idx_r;
    lo_idx_nxt    = lo_idx_r;
    out_valid_nxt = 1'b0;
    out_victim_nxt = out_victim_r;
    out_mapped_nxt = out_mapped_r;
    out_oom_nxt    = out_oom_r;

    if (cfg_we) begin
      policy_nxt = cfg_wdata;
    end

    // per-frame step of the scan, in the cycle after its RAM address
    if (proc_v_r) begin
      if (kind_r == KIND_AGE) begin
        if (p_map) begin
          age_vld_nxt[proc_idx_r] = 1'b1;
        end
      end else if (!p_prot) begin
        seen_nxt     = 1'b1;
        last_idx_nxt = proc_idx_r;
        if (!p_map && !free_hit_r) begin
          free_hit_nxt = 1'b1;
          free_idx_nxt = proc_idx_r;
        end
        if (p_coin && !rnd_hit_r) begin
          rnd_hit_nxt = 1'b1;
          rnd_idx_nxt = proc_idx_r;
        end
        // strict compare keeps the lowest index on a tie
        if (!seen_r || (p_age < lru_val_r)) begin
          lru_idx_nxt = proc_idx_r;
          lru_val_nxt = p_age;
        end
        if (!seen_r) begin
          lo_idx_nxt = proc_idx_r;
        end
        if (!hi_hit_r && (proc_idx_r > fifo_ptr_r)) begin
          hi_hit_nxt = 1'b1;
          hi_idx_nxt = proc_idx_r;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt     = in_kind;
          ref_nxt      = in_ref_mask;
          coin_nxt     = in_random_bits;
          cnt_nxt      = '0;
          free_hit_nxt = 1'b0;
          seen_nxt     = 1'b0;
          rnd_hit_nxt  = 1'b0;
          hi_hit_nxt   = 1'b0;
          if ((in_kind == KIND_SELECT) || (in_kind == KIND_AGE)) begin
            state_nxt = ST_SCAN;
          end else if (in_kind == KIND_FLAGS) begin
            if (9'(in_frame) < 9'(FRAME_COUNT)) begin
              for (int i = 0; i < FRAME_COUNT; i++) begin
                if (9'(i) == 9'(in_frame)) begin
                  map_nxt[i]  = in_mapped;
                  prot_nxt[i] = in_protected_bit;
                end
              end
            end
          end
        end
      end
      ST_SCAN: begin
        proc_v_nxt   = 1'b1;
        proc_idx_nxt = cnt_r;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        if (kind_r == KIND_SELECT) begin
          out_valid_nxt = 1'b1;
          if (found) begin
            out_victim_nxt = pick9[VICTIM_W-1:0];
            out_mapped_nxt = map_r[pick];
            out_oom_nxt    = 1'b0;
            if (!free_hit_r && (policy_r == POL_FIFO)) begin
              fifo_ptr_nxt = pick;
            end
          end else begin
            out_victim_nxt = '0;
            out_mapped_nxt = 1'b0;
            out_oom_nxt    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      proc_v_r    <= 1'b0;
      policy_r    <= POL_RANDOM;
      map_r       <= '0;
      prot_r      <= '0;
      age_vld_r   <= '0;
      fifo_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      proc_v_r    <= proc_v_nxt;
      policy_r    <= policy_nxt;
      map_r       <= map_nxt;
      prot_r      <= prot_nxt;
      age_vld_r   <= age_vld_nxt;
      fifo_ptr_r  <= fifo_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r   <= proc_idx_nxt;
    kind_r       <= kind_nxt;
    ref_r        <= ref_nxt;
    coin_r       <= coin_nxt;
    free_hit_r   <= free_hit_nxt;
    free_idx_r   <= free_idx_nxt;
    seen_r       <= seen_nxt;
    last_idx_r   <= last_idx_nxt;
    rnd_hit_r    <= rnd_hit_nxt;
    rnd_idx_r    <= rnd_idx_nxt;
    lru_idx_r    <= lru_idx_nxt;
    lru_val_r    <= lru_val_nxt;
    hi_hit_r     <= hi_hit_nxt;
    hi_idx_r     <= hi_idx_nxt;
    lo_idx_r     <= lo_idx_nxt;
    out_victim_r <= out_victim_nxt;
    out_mapped_r <= out_mapped_nxt;
    out_oom_r    <= out_oom_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_victim            = out_victim_r;
  assign out_victim_was_mapped = out_mapped_r;
  assign out_out_of_memory     = out_oom_r;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the page frame victim selector.
module tb_top;
  import pfvs_pkg::*;

  localparam int FRAMES       = 16;
  localparam int PHASE_BEATS  = 75;
  localparam int DRAIN_CYCLES = FRAMES + 8;
  localparam kind_t   KIND_UNUSED = 2'd3;
  localparam policy_t POL_UNUSED  = 2'd3;

  typedef struct packed {
    logic [VICTIM_W-1:0] victim;
    logic                was_mapped;
    logic                out_of_memory;
  } victim_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  kind_t               in_kind = KIND_SELECT;
  logic [FRAME_W-1:0]  in_frame = '0;
  logic                in_mapped = 1'b0;
  logic                in_protected_bit = 1'b0;
  logic [MASK_W-1:0]   in_ref_mask = '0;
  logic [MASK_W-1:0]   in_random_bits = '0;
  logic                cfg_we = 1'b0;
  policy_t             cfg_wdata = POL_RANDOM;
  logic                out_valid;
  logic [VICTIM_W-1:0] out_victim;
  logic                out_victim_was_mapped;
  logic                out_out_of_memory;

  // frame table as the block should hold it
  logic [FRAMES-1:0]  mapped_q = '0;
  logic [FRAMES-1:0]  prot_q = '0;
  age_t               age_q [FRAMES] = '{default: '0};
  logic [FRAME_W-1:0] fifo_ptr_q = '0;
  policy_t            policy_q = POL_RANDOM;

  victim_t expected_victims [$];
  int      mismatch_count = 0;
  int      beats_sent = 0;
  int      victims_checked = 0;
  int      oom_seen = 0;
  int      idle_pct = 0;

  page_frame_victim_select_top #(.FRAME_COUNT(FRAMES)) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_frame              (in_frame),
    .in_mapped             (in_mapped),
    .in_protected_bit      (in_protected_bit),
    .in_ref_mask           (in_ref_mask),
    .in_random_bits        (in_random_bits),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_victim            (out_victim),
    .out_victim_was_mapped (out_victim_was_mapped),
    .out_out_of_memory     (out_out_of_memory)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Victim the block should return for a select beat; moves the FIFO pointer.
  function automatic victim_t pick_victim(input logic [MASK_W-1:0] coins);
    victim_t            res;
    logic               found;
    logic               hit;
    logic [FRAME_W-1:0] pick;
    logic [FRAME_W-1:0] f;
    res   = '0;
    found = 1'b0;
    hit   = 1'b0;
    pick  = '0;
    for (int i = 0; i < FRAMES; i++)
      if (!found && !prot_q[i] && !mapped_q[i]) begin
        pick  = FRAME_W'(i);
        found = 1'b1;
      end
    if (!found) begin
      case (policy_q)
        POL_RANDOM:
          // last unprotected frame unless a coin fires first
          for (int i = 0; i < FRAMES; i++)
            if (!hit && !prot_q[i]) begin
              pick  = FRAME_W'(i);
              found = 1'b1;
              hit   = coins[i];
            end
        POL_LRU:
          for (int i = 0; i < FRAMES; i++)
            if (!prot_q[i]) begin
              if (!found || age_q[i] < age_q[pick]) pick = FRAME_W'(i);
              found = 1'b1;
            end
        POL_FIFO: begin
          // scan wraps round to the pointer itself
          for (int k = 1; k <= FRAMES; k++) begin
            f = fifo_ptr_q + FRAME_W'(k);
            if (!found && !prot_q[f]) begin
              pick  = f;
              found = 1'b1;
            end
          end
          if (found) fifo_ptr_q = pick;
        end
        default: ;
      endcase
    end
    if (found) begin
      res.victim     = pick;
      res.was_mapped = mapped_q[pick];
    end else begin
      res.out_of_memory = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_victims
    victim_t want;
    if (rst_n && out_valid) begin
      victims_checked++;
      if (out_out_of_memory) oom_seen++;
      if (expected_victims.size() == 0) begin
        report_mismatch("result with none expected", out_victim, 0);
      end else begin
        want = expected_victims.pop_front();
        if (out_victim !== want.victim)
          report_mismatch("victim", out_victim, want.victim);
        if (out_victim_was_mapped !== want.was_mapped)
          report_mismatch("victim_was_mapped", out_victim_was_mapped, want.was_mapped);
        if (out_out_of_memory !== want.out_of_memory)
          report_mismatch("out_of_memory", out_out_of_memory, want.out_of_memory);
      end
    end
  end

  // Drives one beat, waits for it to be taken, then updates the frame table.
  // start is left high so the next beat can follow without a gap.
  task automatic send_beat(input kind_t k, input logic [FRAME_W-1:0] f,
                           input logic m, input logic p,
                           input logic [MASK_W-1:0] refm,
                           input logic [MASK_W-1:0] coins);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
    in_kind          <= k;
    in_frame         <= f;
    in_mapped        <= m;
    in_protected_bit <= p;
    in_ref_mask      <= refm;
    in_random_bits   <= coins;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
    case (k)
      KIND_SELECT: expected_victims.push_back(pick_victim(coins));
      KIND_AGE:
        for (int i = 0; i < FRAMES; i++)
          if (mapped_q[i]) age_q[i] = {refm[i], age_q[i][AGE_W-1:1]};
      KIND_FLAGS: begin
        mapped_q[f] = m;
        prot_q[f]   = p;
      end
      default: ;
    endcase
  endtask

  task automatic set_policy(input policy_t pol);
    start <= 1'b0;
    while (expected_victims.size() != 0) @(posedge clk);
    // an ageing beat gives no result but may still be scanning
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_wdata <= pol;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    policy_q = pol;
  endtask

  task automatic test_out_of_memory();
    for (int f = 0; f < FRAMES; f++)
      send_beat(KIND_FLAGS, FRAME_W'(f), 1'b1, 1'b1, '0, '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '1);
  endtask

  task automatic test_random_policy();
    send_beat(KIND_FLAGS, FRAME_W'(3), 1'b1, 1'b0, '0, '0);
    send_beat(KIND_FLAGS, FRAME_W'(12), 1'b1, 1'b0, '0, '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '1);
  endtask

  task automatic test_aging_lru();
    set_policy(POL_LRU);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '0);
    send_beat(KIND_AGE, '0, 1'b0, 1'b0, '1, '0);
    send_beat(KIND_AGE, '0, 1'b0, 1'b0, MASK_W'(16'h0008), '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '0);
  endtask

  task automatic test_fifo_wrap();
    set_policy(POL_FIFO);
    repeat (3) send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '0);
    // only the frame under the pointer left
    send_beat(KIND_FLAGS, FRAME_W'(12), 1'b1, 1'b1, '0, '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '0);
  endtask

  task automatic test_unused_codes();
    set_policy(POL_UNUSED);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '1);
    send_beat(KIND_FLAGS, FRAME_W'(7), 1'b0, 1'b0, '0, '0);
    send_beat(KIND_SELECT, '0, 1'b0, 1'b0, '0, '1);
    send_beat(KIND_UNUSED, '1, 1'b1, 1'b1, '1, '1);
  endtask

  task automatic test_random_traffic();
    policy_t            pol_order [4];
    int                 idle_order [3];
    int                 sent;
    int                 r;
    int                 sweep_pct;
    logic [FRAME_W-1:0] f;
    logic               m;
    logic               p;
    logic [MASK_W-1:0]  refm;
    logic [MASK_W-1:0]  coins;
    pol_order[0]  = POL_RANDOM;
    pol_order[1]  = POL_LRU;
    pol_order[2]  = POL_FIFO;
    pol_order[3]  = POL_UNUSED;
    idle_order[0] = 0;
    idle_order[1] = 65;
    idle_order[2] = 35;
    for (int ph = 0; ph < 12; ph++) begin
      set_policy(pol_order[ph % 4]);
      idle_pct = idle_order[ph / 4];
      sent = 0;
      while (sent < PHASE_BEATS) begin
        // mostly mapped frames, so selects get past the free-frame check
        f = FRAME_W'($urandom_range(FRAMES - 1));
        m = ($urandom_range(99) < 95);
        p = ($urandom_range(99) < 20);
        case ($urandom_range(7))
          0:       refm = '0;
          1:       refm = '1;
          default: refm = MASK_W'($urandom);
        endcase
        case ($urandom_range(3))
          0:       coins = '0;
          1:       coins = MASK_W'(1) << $urandom_range(MASK_W - 1);
          default: coins = MASK_W'($urandom);
        endcase
        r = $urandom_range(99);
        if (r < 2) begin
          // rewrite every frame; the heavy variant mostly runs out of memory
          sweep_pct = $urandom_range(1) ? 97 : 10;
          for (int i = 0; i < FRAMES; i++)
            send_beat(KIND_FLAGS, FRAME_W'(i), $urandom_range(99) < 95,
                      $urandom_range(99) < sweep_pct, refm, coins);
          sent += FRAMES;
        end else if (r < 32) begin
          send_beat(KIND_SELECT, f, m, p, refm, coins);
          sent++;
        end else if (r < 57) begin
          send_beat(KIND_AGE, f, m, p, refm, coins);
          sent++;
        end else if (r < 98) begin
          send_beat(KIND_FLAGS, f, m, p, refm, coins);
          sent++;
        end else begin
          send_beat(KIND_UNUSED, f, m, p, refm, coins);
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_out_of_memory();
    test_random_policy();
    test_aging_lru();
    test_fifo_wrap();
    test_unused_codes();
    test_random_traffic();
    start <= 1'b0;
    while (expected_victims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d beats taken, %0d victims checked, %0d out of memory",
             beats_sent, victims_checked, oom_seen);
    $display("summary: all four policy codes, no sender gaps and 65/35 percent gaps");
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout: block stopped responding");
    $display("tb_top: errors");
    $finish;
  end

endmodule
